### rtl/otb_pkg.sv
// Shared types and constants for the Otsu threshold binarizer.
`default_nettype none
package otb_pkg;

    localparam int NUM_BINS = 256;
    localparam logic [7:0] LEVEL_MAX = 8'd255;
    localparam logic [7:0] LEVEL_MIN = 8'd0;

    localparam logic FUNC_LOAD     = 1'b0;
    localparam logic FUNC_CLASSIFY = 1'b1;

    localparam logic KIND_THRESH = 1'b0;
    localparam logic KIND_PIXEL  = 1'b1;

    // Decoded operation of one queued item
    typedef enum logic [1:0] {
        OP_CLASSIFY,
        OP_LOAD,
        OP_LOAD_LAST
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] pixel;
    } item_t;

    // Head of the item queue as seen by the back end
    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

endpackage
`default_nettype wire

### rtl/otb_front.sv
// Front end: accepts items, decodes them and queues them for the back end.
`default_nettype none
module otb_front
    import otb_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    output logic            item_stall,
    input  wire logic       func,
    input  wire logic [7:0] pixel,
    input  wire logic       last,
    output head_t           head,
    input  wire logic       pop
);

    item_t      queue_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    item_t      item_in;

    // Classify the item before it enters the queue
    always_comb
    begin
        item_in.pixel = pixel;
        if (func == FUNC_CLASSIFY)
            item_in.op = OP_CLASSIFY;
        else if (last)
            item_in.op = OP_LOAD_LAST;
        else
            item_in.op = OP_LOAD;
    end

    assign item_stall = (count_reg == 2'd2);
    assign push       = item_valid && !item_stall;
    assign head.valid = (count_reg != 2'd0);
    assign head.item  = queue_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            queue_reg[wr_ptr_reg] <= item_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule
`default_nettype wire

### rtl/otb_mul.sv
// Shared shift-and-add multiplier, one multiplier bit per cycle.
`default_nettype none
module otb_mul #(
    parameter int AW = 100,
    parameter int BW = 50,
    parameter int PW = 142
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [AW-1:0] a,
    input  wire logic [BW-1:0] b,
    output logic               done,
    output logic [PW-1:0]      product
);

    logic [PW-1:0] a_sh_reg;
    logic [BW-1:0] b_sh_reg;
    logic [PW-1:0] acc_reg;
    logic          busy_reg;
    logic          done_reg;

    assign done    = done_reg;
    assign product = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            a_sh_reg <= '0;
            b_sh_reg <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (b_sh_reg == '0);
            if (start)
            begin
                a_sh_reg <= PW'(a);
                b_sh_reg <= b;
                acc_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (b_sh_reg == '0)
                    busy_reg <= 1'b0;
                else
                begin
                    if (b_sh_reg[0])
                        acc_reg <= acc_reg + a_sh_reg;
                    a_sh_reg <= {a_sh_reg[PW-2:0], 1'b0};
                    b_sh_reg <= {1'b0, b_sh_reg[BW-1:1]};
                end
            end
        end
    end

endmodule
`default_nettype wire

### rtl/otb_back.sv
// Back end: histogram memory, threshold search sequencer and result register.
`default_nettype none
module otb_back
    import otb_pkg::*;
#(
    parameter int COUNT_BITS = 21
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire head_t      head,
    output logic            pop,
    output logic            result_valid,
    input  wire logic       result_stall,
    output logic            kind,
    output logic [7:0]      value
);

    localparam int CW = COUNT_BITS;
    localparam int SW = COUNT_BITS + 8;
    localparam int DW = 2 * COUNT_BITS + 8;
    localparam int NW = 4 * COUNT_BITS + 16;
    localparam int EW = 2 * COUNT_BITS;
    localparam int PW = 6 * COUNT_BITS + 16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD_WR,
        ST_S_READ,
        ST_S_ACC,
        ST_S_CHECK,
        ST_MUL_WAIT,
        ST_DIFF,
        ST_NEXT,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        MUL_P,
        MUL_Q,
        MUL_NUM,
        MUL_DEN,
        MUL_LHS,
        MUL_RHS
    } mul_op_t;

    state_t          state_reg;
    mul_op_t         mul_op_reg;
    logic            mul_start_reg;
    logic            mul_done;
    logic [PW-1:0]   mul_prod;
    logic [NW-1:0]   mul_a;
    logic [DW-1:0]   mul_b;
    logic            mul_kick;

    logic [CW-1:0]   hist_mem [NUM_BINS];
    logic [NUM_BINS-1:0] hvalid_reg;
    logic [CW-1:0]   rd_data_reg;
    logic            rd_valid_reg;
    logic [7:0]      mem_raddr;
    logic            mem_we;
    logic [CW-1:0]   mem_wdata;
    logic [CW-1:0]   bin_count;

    logic [CW-1:0]   total_reg;
    logic [SW-1:0]   sum_reg;
    logic [7:0]      cur_pixel_reg;
    logic            cur_last_reg;
    logic [7:0]      t_reg;
    logic [CW-1:0]   n0_reg;
    logic [SW-1:0]   s0_reg;
    logic [CW-1:0]   n1;
    logic [SW-1:0]   bin_weight;
    logic [DW-1:0]   p_reg;
    logic [DW-1:0]   q_reg;
    logic [DW-1:0]   diff_reg;
    logic [NW-1:0]   num_reg;
    logic [EW-1:0]   den_reg;
    logic [PW-1:0]   lhs_reg;
    logic [NW-1:0]   best_num_reg;
    logic [EW-1:0]   best_den_reg;
    logic [7:0]      best_t_reg;
    logic [7:0]      thresh_reg;

    logic            res_valid_reg;
    logic            kind_reg;
    logic [7:0]      value_reg;
    logic            out_free;
    logic            count_full;
    logic            res_set;

    assign result_valid = res_valid_reg;
    assign kind         = kind_reg;
    assign value        = value_reg;
    assign out_free     = !res_valid_reg || !result_stall;
    assign count_full   = (total_reg == {CW{1'b1}});
    assign bin_count    = rd_valid_reg ? rd_data_reg : '0;
    assign n1           = total_reg - n0_reg;
    assign bin_weight   = SW'(bin_count) * SW'(t_reg);

    // Pop a classify item only when the result register can take it
    always_comb
    begin
        pop = 1'b0;
        if (state_reg == ST_IDLE && head.valid)
        begin
            if (head.item.op == OP_CLASSIFY)
                pop = out_free;
            else
                pop = 1'b1;
        end
    end

    // Load the result register on a classify pop or a threshold emit
    assign res_set = (state_reg == ST_IDLE && pop && head.item.op == OP_CLASSIFY) ||
                     (state_reg == ST_EMIT && out_free);

    // Start the next product of the chain
    always_comb
    begin
        mul_kick = 1'b0;
        case (state_reg)
            ST_S_CHECK:
                mul_kick = !(n0_reg == '0 || n1 == '0);
            ST_MUL_WAIT:
                mul_kick = mul_done &&
                           (mul_op_reg inside {MUL_P, MUL_NUM, MUL_DEN, MUL_LHS});
            ST_DIFF:
                mul_kick = 1'b1;
            default:
                mul_kick = 1'b0;
        endcase
    end

    always_comb
    begin
        mem_raddr = (state_reg == ST_S_READ) ? t_reg : head.item.pixel;
        mem_we    = (state_reg == ST_LOAD_WR);
        mem_wdata = bin_count + CW'(1);
    end

    // Operand select for the shared multiplier
    always_comb
    begin
        case (mul_op_reg)
            MUL_P:
            begin
                mul_a = NW'(s0_reg);
                mul_b = DW'(total_reg);
            end
            MUL_Q:
            begin
                mul_a = NW'(sum_reg);
                mul_b = DW'(n0_reg);
            end
            MUL_NUM:
            begin
                mul_a = NW'(diff_reg);
                mul_b = diff_reg;
            end
            MUL_DEN:
            begin
                mul_a = NW'(n1);
                mul_b = DW'(n0_reg);
            end
            MUL_LHS:
            begin
                mul_a = num_reg;
                mul_b = DW'(best_den_reg);
            end
            MUL_RHS:
            begin
                mul_a = best_num_reg;
                mul_b = DW'(den_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    otb_mul #(
        .AW (NW),
        .BW (DW),
        .PW (PW)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start_reg),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_prod)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
            hist_mem[cur_pixel_reg] <= mem_wdata;
        rd_data_reg <= hist_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mul_op_reg    <= MUL_P;
            mul_start_reg <= 1'b0;
            hvalid_reg    <= '0;
            rd_valid_reg  <= 1'b0;
            total_reg     <= '0;
            sum_reg       <= '0;
            cur_pixel_reg <= '0;
            cur_last_reg  <= 1'b0;
            t_reg         <= '0;
            n0_reg        <= '0;
            s0_reg        <= '0;
            p_reg         <= '0;
            q_reg         <= '0;
            diff_reg      <= '0;
            num_reg       <= '0;
            den_reg       <= '0;
            lhs_reg       <= '0;
            best_num_reg  <= '0;
            best_den_reg  <= '0;
            best_t_reg    <= '0;
            thresh_reg    <= '0;
            res_valid_reg <= 1'b0;
            kind_reg      <= KIND_PIXEL;
            value_reg     <= '0;
        end
        else
        begin
            mul_start_reg <= mul_kick;
            rd_valid_reg  <= hvalid_reg[mem_raddr];
            if (res_set)
                res_valid_reg <= 1'b1;
            else if (res_valid_reg && !result_stall)
                res_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        cur_pixel_reg <= head.item.pixel;
                        cur_last_reg  <= (head.item.op == OP_LOAD_LAST);
                        if (head.item.op == OP_CLASSIFY)
                        begin
                            kind_reg      <= KIND_PIXEL;
                            value_reg     <= (head.item.pixel >= thresh_reg) ?
                                             LEVEL_MAX : LEVEL_MIN;
                        end
                        else if (!count_full)
                            state_reg <= ST_LOAD_WR;
                        else if (head.item.op == OP_LOAD_LAST)
                        begin
                            t_reg        <= '0;
                            n0_reg       <= '0;
                            s0_reg       <= '0;
                            best_num_reg <= '0;
                            best_den_reg <= EW'(1);
                            best_t_reg   <= '0;
                            state_reg    <= ST_S_READ;
                        end
                    end
                end

                ST_LOAD_WR:
                begin
                    hvalid_reg[cur_pixel_reg] <= 1'b1;
                    total_reg <= total_reg + CW'(1);
                    sum_reg   <= sum_reg + SW'(cur_pixel_reg);
                    if (cur_last_reg)
                    begin
                        t_reg        <= '0;
                        n0_reg       <= '0;
                        s0_reg       <= '0;
                        best_num_reg <= '0;
                        best_den_reg <= EW'(1);
                        best_t_reg   <= '0;
                        state_reg    <= ST_S_READ;
                    end
                    else
                        state_reg <= ST_IDLE;
                end

                ST_S_READ:
                    state_reg <= ST_S_ACC;

                ST_S_ACC:
                begin
                    n0_reg    <= n0_reg + bin_count;
                    s0_reg    <= s0_reg + bin_weight;
                    state_reg <= ST_S_CHECK;
                end

                ST_S_CHECK:
                begin
                    // Skip a threshold that leaves either class empty
                    if (n0_reg == '0 || n1 == '0)
                        state_reg <= ST_NEXT;
                    else
                    begin
                        mul_op_reg    <= MUL_P;
                        state_reg     <= ST_MUL_WAIT;
                    end
                end

                ST_MUL_WAIT:
                begin
                    if (mul_done)
                    begin
                        case (mul_op_reg)
                            MUL_P:
                            begin
                                p_reg         <= DW'(mul_prod);
                                mul_op_reg    <= MUL_Q;
                            end
                            MUL_Q:
                            begin
                                q_reg     <= DW'(mul_prod);
                                state_reg <= ST_DIFF;
                            end
                            MUL_NUM:
                            begin
                                num_reg       <= NW'(mul_prod);
                                mul_op_reg    <= MUL_DEN;
                            end
                            MUL_DEN:
                            begin
                                den_reg       <= EW'(mul_prod);
                                mul_op_reg    <= MUL_LHS;
                            end
                            MUL_LHS:
                            begin
                                lhs_reg       <= mul_prod;
                                mul_op_reg    <= MUL_RHS;
                            end
                            MUL_RHS:
                            begin
                                // Strictly greater wins; ties keep the earlier t
                                if (lhs_reg > mul_prod)
                                begin
                                    best_num_reg <= num_reg;
                                    best_den_reg <= den_reg;
                                    best_t_reg   <= t_reg;
                                end
                                state_reg <= ST_NEXT;
                            end
                            default:
                                state_reg <= ST_NEXT;
                        endcase
                    end
                end

                ST_DIFF:
                begin
                    diff_reg      <= (p_reg >= q_reg) ? (p_reg - q_reg) : (q_reg - p_reg);
                    mul_op_reg    <= MUL_NUM;
                    state_reg     <= ST_MUL_WAIT;
                end

                ST_NEXT:
                begin
                    if (t_reg == LEVEL_MAX)
                    begin
                        // Sweep done: keep the threshold, drop the histogram
                        thresh_reg <= best_t_reg;
                        hvalid_reg <= '0;
                        total_reg  <= '0;
                        sum_reg    <= '0;
                        state_reg  <= ST_EMIT;
                    end
                    else
                    begin
                        t_reg     <= t_reg + 8'd1;
                        state_reg <= ST_S_READ;
                    end
                end

                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        kind_reg      <= KIND_THRESH;
                        value_reg     <= thresh_reg;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

### rtl/otsu_threshold_binarizer_unit.sv
// Top level of the Otsu threshold binarizer.
`default_nettype none
// An item carries func, pixel and last. A load item (func 0) adds its pixel
// to a 256-bin histogram in the back end, by a memory read and then a write;
// a classify item (func 1) returns 255 when pixel >= the current threshold,
// else 0 (the threshold is 0 after reset). The load item marked last starts
// a sweep over all 256 thresholds that finds the Otsu threshold in exact
// integer arithmetic, returns it with kind 0 and clears the histogram. The
// sweep runs on one shared shift-and-add multiplier, six products per
// threshold that leaves both classes non-empty; a product ends once no set
// bit of its second operand remains. A two-entry queue between the front
// end and the back end holds up to two items while the back end is busy or
// a result waits on stall.
// COUNT_BITS sets the width of each histogram bin and of the pixel count;
// loads beyond 2^COUNT_BITS - 1 pixels are not counted.
module otsu_threshold_binarizer_unit
    import otb_pkg::*;
#(
    parameter int COUNT_BITS = 21
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    output logic            item_stall,
    input  wire logic       func,
    input  wire logic [7:0] pixel,
    input  wire logic       last,
    output logic            result_valid,
    input  wire logic       result_stall,
    output logic            kind,
    output logic [7:0]      value
);

    head_t head;
    logic  pop;

    // Decode and queue items
    otb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .func       (func),
        .pixel      (pixel),
        .last       (last),
        .head       (head),
        .pop        (pop)
    );

    // Histogram, threshold search and result register
    otb_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .kind         (kind),
        .value        (value)
    );

endmodule
`default_nettype wire
